FILE: sv/m3h_pkg.sv
package m3h_pkg;

	// Mixing and finalizer constants
	localparam logic [63:0] MIX_C1    = 64'h87c3_7b91_1142_53d5;
	localparam logic [63:0] MIX_C2    = 64'h4cf5_ad43_2745_937f;
	localparam logic [63:0] LANE1_ADD = 64'h0000_0000_52dc_e729;
	localparam logic [63:0] LANE2_ADD = 64'h0000_0000_3849_5ab5;
	localparam logic [63:0] FIN_M1    = 64'hff51_afd7_ed55_8ccd;
	localparam logic [63:0] FIN_M2    = 64'hc4ce_b9fe_1a85_ec53;

	localparam int          BLOCK_BYTES = 16;
	localparam logic [4:0]  FULL_COUNT  = 5'(BLOCK_BYTES);

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Register map (index in words)
	localparam logic REG_SEED = 1'b0;

	// One classified block as handed to the back end
	typedef struct packed {
		logic [63:0] k1;       // masked low word
		logic [63:0] k2;       // masked high word
		logic        chain;    // full block: run the lane chain
		logic        last;     // finalize after this block
		logic [4:0]  add_len;  // bytes added to the running length
	} m3h_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} m3h_qstat_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} m3h_mreq_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] p;
	} m3h_mstat_t;

	function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned s);
		return (v << s) | (v >> (64 - s));
	endfunction

	// fmix64 shift-xor step
	function automatic logic [63:0] fold33(input logic [63:0] v);
		return v ^ (v >> 33);
	endfunction

endpackage

FILE: sv/murmur3_128_stream_hash.sv
// 128-bit MurmurHash3 (x64 variant) over a stream of 16-byte blocks.
// Input channel: in_valid/in_stall with data_low, data_high (little-endian
// block words), byte_count and is_last. A request is taken when in_valid is
// high and in_stall low. A two-entry queue sits behind the input, so up to
// two blocks are taken while the hash core is busy.
// Output channel: out_valid/out_stall with hash_low/hash_high, one request
// per message, held in an output register until taken.
// The core shares one 32x32 multiplier for all of its 64-bit multiplies.
// A full block runs four multiplies plus the lane chain, a short last block
// only the four multiplies; the last block of a message adds finalization
// with four more multiplies.
// The seed register (APB, address 0) is loaded into both lanes when the
// first block of a message reaches the core.
// Reset clears the queue, the output register and the message state.
// A stalled output holds the result; the core waits with the next result
// until the register is free, meanwhile the queue fills and in_stall rises.
module murmur3_128_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input blocks
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_low,
	input  logic [63:0] data_high,
	input  logic [4:0]  byte_count,
	input  logic        is_last,
	// hash results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_low,
	output logic [63:0] hash_high
);
	import m3h_pkg::*;

	logic        seed_q;
	logic [31:0] seed_val_q;
	logic        push;
	logic        pop;
	m3h_item_t   wr_item;
	m3h_item_t   head;
	m3h_qstat_t  qstat;

	// Seed register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_val_q <= '0;
			seed_q     <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_SEED)) begin
			seed_val_q <= pwdata;
			seed_q     <= 1'b1;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SEED) ? seed_val_q : 32'h0;

	m3h_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_low   (data_low),
		.data_high  (data_high),
		.byte_count (byte_count),
		.is_last    (is_last),
		.qstat      (qstat),
		.push       (push),
		.item       (wr_item)
	);

	m3h_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	m3h_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed_val_q),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hash_low  (hash_low),
		.hash_high (hash_high)
	);

	// seed written at least once since reset; reset value zero serves before that
	a_seed_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!seed_q |-> (seed_val_q == 32'h0)) else $error("seed changed without a write");

endmodule

FILE: sv/m3h_front.sv
module m3h_front (
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [63:0]            data_low,
	input  logic [63:0]            data_high,
	input  logic [4:0]             byte_count,
	input  logic                   is_last,
	input  m3h_pkg::m3h_qstat_t    qstat,
	output logic                   push,
	output m3h_pkg::m3h_item_t     item
);
	import m3h_pkg::*;

	logic [4:0]  cnt;
	logic        full_blk;
	logic [15:0] keep;

	// Clamp count, decide full block or tail
	assign cnt      = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
	assign full_blk = !is_last || (cnt == FULL_COUNT);

	// Byte keep mask for tails
	always_comb begin
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			keep[i] = full_blk || (5'(i) < cnt);
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			item.k1[8*i +: 8] = keep[i]     ? data_low[8*i +: 8]  : 8'h00;
			item.k2[8*i +: 8] = keep[i + 8] ? data_high[8*i +: 8] : 8'h00;
		end
		item.chain   = full_blk;
		item.last    = is_last;
		item.add_len = is_last ? cnt : FULL_COUNT;
	end

	// Accept whenever the queue has room
	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

endmodule

FILE: sv/m3h_fifo.sv
module m3h_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  m3h_pkg::m3h_item_t   wr_item,
	input  logic                 pop,
	output m3h_pkg::m3h_item_t   head,
	output m3h_pkg::m3h_qstat_t  qstat
);
	import m3h_pkg::*;

	m3h_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full) else $error("push into full queue");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("pop from empty queue");

endmodule

FILE: sv/m3h_mul.sv
module m3h_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  m3h_pkg::m3h_mreq_t  mreq,
	output m3h_pkg::m3h_mstat_t mstat
);
	import m3h_pkg::*;

	typedef enum logic [1:0] {PH_LL, PH_LH, PH_HL} phase_t;

	phase_t      phase_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [31:0] x;
	logic [31:0] y;
	logic [63:0] prod;

	// One 32x32 partial product per cycle; low 64 bits of a*b
	assign x    = (phase_q == PH_HL) ? a_q[63:32] : a_q[31:0];
	assign y    = (phase_q == PH_LH) ? b_q[63:32] : b_q[31:0];
	assign prod = 64'(x) * 64'(y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LL;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			acc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (mreq.start) begin
				a_q     <= mreq.a;
				b_q     <= mreq.b;
				phase_q <= PH_LL;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				case (phase_q)
					PH_LL: begin
						acc_q   <= prod;
						phase_q <= PH_LH;
					end
					PH_LH: begin
						acc_q   <= acc_q + {prod[31:0], 32'h0};
						phase_q <= PH_HL;
					end
					PH_HL: begin
						acc_q   <= acc_q + {prod[31:0], 32'h0};
						phase_q <= PH_LL;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end
					default: phase_q <= PH_LL;
				endcase
			end
		end
	end

	assign mstat.busy = busy_q;
	assign mstat.done = done_q;
	assign mstat.p    = acc_q;

endmodule

FILE: sv/m3h_core.sv
module m3h_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          seed,
	input  m3h_pkg::m3h_item_t   head,
	input  m3h_pkg::m3h_qstat_t  qstat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [63:0]          hash_low,
	output logic [63:0]          hash_high
);
	import m3h_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_K1A, ST_K1B, ST_K2A, ST_K2B,
		ST_H1A, ST_H1B, ST_H2A, ST_H2B,
		ST_FIN0, ST_FIN1, ST_F1A, ST_F1B, ST_F2A, ST_F2B, ST_FIN2, ST_FIN3
	} state_t;

	state_t      st_q;
	logic [63:0] h1_q;
	logic [63:0] h2_q;
	logic [63:0] len_q;
	logic        msg_start_q;
	logic [63:0] k1_q;
	logic [63:0] k2_q;
	logic        chain_q;
	logic        last_q;
	logic [4:0]  add_len_q;
	logic        out_valid_q;
	logic [63:0] hash_low_q;
	logic [63:0] hash_high_q;
	logic        out_free;

	m3h_mreq_t   mreq;
	m3h_mstat_t  mstat;

	m3h_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.mstat  (mstat)
	);

	assign pop      = (st_q == ST_IDLE) && !qstat.empty;
	assign out_free = !out_valid_q || !out_stall;

	// Multiply requests for scramble and finalizer steps
	always_comb begin
		mreq.start = 1'b0;
		mreq.a     = '0;
		mreq.b     = '0;
		case (st_q)
			ST_IDLE: begin
				mreq.start = !qstat.empty;
				mreq.a     = head.k1;
				mreq.b     = MIX_C1;
			end
			ST_K1A: begin
				mreq.start = mstat.done;
				mreq.a     = rotl(mstat.p, 31);
				mreq.b     = MIX_C2;
			end
			ST_K1B: begin
				mreq.start = mstat.done;
				mreq.a     = k2_q;
				mreq.b     = MIX_C2;
			end
			ST_K2A: begin
				mreq.start = mstat.done;
				mreq.a     = rotl(mstat.p, 33);
				mreq.b     = MIX_C1;
			end
			ST_FIN1: begin
				mreq.start = 1'b1;
				mreq.a     = fold33(h1_q);
				mreq.b     = FIN_M1;
			end
			ST_F1A: begin
				mreq.start = mstat.done;
				mreq.a     = fold33(mstat.p);
				mreq.b     = FIN_M2;
			end
			ST_F1B: begin
				mreq.start = mstat.done;
				mreq.a     = fold33(h2_q);
				mreq.b     = FIN_M1;
			end
			ST_F2A: begin
				mreq.start = mstat.done;
				mreq.a     = fold33(mstat.p);
				mreq.b     = FIN_M2;
			end
			default: mreq.start = 1'b0;
		endcase
	end

	// Sequencer, lanes and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			h1_q        <= '0;
			h2_q        <= '0;
			len_q       <= '0;
			msg_start_q <= 1'b1;
			k1_q        <= '0;
			k2_q        <= '0;
			chain_q     <= 1'b0;
			last_q      <= 1'b0;
			add_len_q   <= '0;
			out_valid_q <= 1'b0;
			hash_low_q  <= '0;
			hash_high_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						if (msg_start_q) begin
							h1_q        <= {32'h0, seed};
							h2_q        <= {32'h0, seed};
							len_q       <= '0;
							msg_start_q <= 1'b0;
						end
						k2_q      <= head.k2;
						chain_q   <= head.chain;
						last_q    <= head.last;
						add_len_q <= head.add_len;
						st_q      <= ST_K1A;
					end
				end
				ST_K1A: if (mstat.done) st_q <= ST_K1B;
				ST_K1B: begin
					if (mstat.done) begin
						k1_q <= mstat.p;
						st_q <= ST_K2A;
					end
				end
				ST_K2A: if (mstat.done) st_q <= ST_K2B;
				ST_K2B: begin
					if (mstat.done) begin
						len_q <= len_q + 64'(add_len_q);
						if (chain_q) begin
							k2_q <= mstat.p;
							st_q <= ST_H1A;
						end else begin
							// tail: lanes take the scrambled words directly
							h1_q <= h1_q ^ k1_q;
							h2_q <= h2_q ^ mstat.p;
							st_q <= last_q ? ST_FIN0 : ST_IDLE;
						end
					end
				end
				// lane one chain
				ST_H1A: begin
					h1_q <= rotl(h1_q ^ k1_q, 27) + h2_q;
					st_q <= ST_H1B;
				end
				ST_H1B: begin
					h1_q <= (h1_q << 2) + h1_q + LANE1_ADD;
					st_q <= ST_H2A;
				end
				// lane two chain
				ST_H2A: begin
					h2_q <= rotl(h2_q ^ k2_q, 31) + h1_q;
					st_q <= ST_H2B;
				end
				ST_H2B: begin
					h2_q <= (h2_q << 2) + h2_q + LANE2_ADD;
					st_q <= last_q ? ST_FIN0 : ST_IDLE;
				end
				// length fold and first cross-add
				ST_FIN0: begin
					h1_q <= (h1_q ^ len_q) + (h2_q ^ len_q);
					h2_q <= h2_q ^ len_q;
					st_q <= ST_FIN1;
				end
				ST_FIN1: begin
					h2_q <= h2_q + h1_q;
					st_q <= ST_F1A;
				end
				ST_F1A: if (mstat.done) st_q <= ST_F1B;
				ST_F1B: begin
					if (mstat.done) begin
						h1_q <= fold33(mstat.p);
						st_q <= ST_F2A;
					end
				end
				ST_F2A: if (mstat.done) st_q <= ST_F2B;
				ST_F2B: begin
					if (mstat.done) begin
						h2_q <= fold33(mstat.p);
						st_q <= ST_FIN2;
					end
				end
				ST_FIN2: begin
					h1_q <= h1_q + h2_q;
					st_q <= ST_FIN3;
				end
				// final cross-add straight into the output register
				ST_FIN3: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hash_low_q  <= h1_q;
						hash_high_q <= h2_q + h1_q;
						msg_start_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign hash_low  = hash_low_q;
	assign hash_high = hash_high_q;

	a_idle_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !mstat.busy) else $error("multiplier busy while idle");
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN3 && out_free) |=> (out_valid_q && st_q == ST_IDLE && msg_start_q))
		else $error("finished hash not posted");

endmodule
